// ----- design/hcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_pkg: shared constants, types and functions of the HDR color packer
// Channel clamp bounds and the per-channel arithmetic helpers.
// ----------------------------------------------------------------------------
package hcp_pkg;

  localparam int unsigned NumLanes = 3;

  localparam logic [31:0] F32Sign    = 32'h8000_0000;
  localparam logic [31:0] F32Frac    = 32'h007F_FFFF;
  localparam logic [31:0] F32ExpMask = 32'h7F80_0000;
  localparam logic [31:0] ClampF11   = 32'h4780_0000;
  localparam logic [31:0] ClampE5    = 32'h477F_8000;
  localparam logic [31:0] FloorE5    = 32'h3780_0000;
  localparam logic [31:0] Rebias112  = 32'h3800_0000;
  localparam logic [31:0] BiasE5     = 32'h0780_4000;

  typedef enum logic {
    OP_F11 = 1'b0,
    OP_E5  = 1'b1
  } op_t;

  // Stage 1 to stage 2 item control
  typedef struct packed {
    logic valid;
    op_t  op;
  } s1_ctl_t;

  // Right shift with round-to-nearest-even; m below 2^24
  function automatic logic [24:0] rne_shr(input logic [23:0] m, input logic [7:0] s);
    logic [24:0] q;
    logic [47:0] ext;
    logic [23:0] r;
    logic [23:0] half;
    logic        gt;
    logic        eq;
    q = '0;
    ext = '0;
    r = '0;
    half = '0;
    gt = 1'b0;
    eq = 1'b0;
    if (s == 8'd0) begin
      q = {1'b0, m};
    end else if (s <= 8'd24) begin
      ext  = {m, 24'd0} >> s;
      q    = {1'b0, ext[47:24]};
      r    = ext[23:0];
      half = 24'h80_0000;
      gt   = r > half;
      eq   = r == half;
      if (gt || (eq && q[0])) q = q + 25'd1;
    end else if (s == 8'd25) begin
      // only a value m above 2^24 would round up; m below 2^24 never exceeds half
      q = '0;
    end
    return q;
  endfunction

endpackage

// ----- design/hcp_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_lane: one color channel
// Clamps one channel, builds its R11G11B10F field and its RGB9E5 operand.
// ----------------------------------------------------------------------------
module hcp_lane
  import hcp_pkg::*;
#(
  parameter int unsigned LSB = 17
) (
  input  logic [31:0] x,
  input  logic        rhe,
  output logic [31:0] f11_u,
  output logic [31:0] e5_x
);

  logic [31:0] xc;
  logic [7:0]  e;
  logic [31:0] u;
  logic [31:0] lsb_bit;

  // Clamp, rebias and round one small-float channel
  always_comb begin
    if (x[31]) xc = '0;
    else if (x > ClampF11) xc = ClampF11;
    else xc = x;
    e = xc[30:23];
    if (e > 8'd112) u = xc - Rebias112;
    else if (e == 8'd0) u = '0;
    else u = 32'(rne_shr({1'b1, xc[22:0]}, 8'd113 - e));
    lsb_bit = 32'((u >> LSB) & 32'd1);
    if (rhe) f11_u = u + ((32'd1 << (LSB - 1)) - 32'd1) + lsb_bit;
    else f11_u = u + (32'd1 << (LSB - 1));
  end

  // Clamp for the shared-exponent format
  always_comb begin
    if (x[31]) e5_x = '0;
    else if ((x & F32ExpMask) == F32ExpMask && (x & F32Frac) != 32'd0) e5_x = '0;
    else if (x > ClampE5) e5_x = ClampE5;
    else e5_x = x;
  end

endmodule

// ----- design/hcp_mant.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_mant: shared-exponent mantissa of one channel
// Aligns a clamped channel to the shared exponent with nearest-even rounding.
// ----------------------------------------------------------------------------
module hcp_mant
  import hcp_pkg::*;
(
  input  logic [31:0] x,
  input  logic [7:0]  eb,
  output logic [8:0]  mant
);

  logic [7:0]  ex;
  logic [23:0] m;
  logic [24:0] q;

  // Align and round
  always_comb begin
    ex = x[30:23];
    m  = {1'b0, x[22:0]};
    if (ex == 8'd0) ex = 8'd1;
    else m[23] = 1'b1;
    q    = rne_shr(m, eb - ex);
    mant = q[8:0];
  end

endmodule

// ----- design/hdr_color_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_color_packer: float RGB to R11G11B10F or RGB9E5 packer
// Three channel lanes, then a merging stage that packs the result word.
// ----------------------------------------------------------------------------
// Usage:
//   in_tdata carries red, green and blue as single-precision bit patterns,
//   in_tuser selects the format (0 = R11G11B10F, 1 = RGB9E5).
//   out_tdata carries the packed 32-bit word, one item per input item.
//   cfg_we/cfg_wdata set round-half-even for R11G11B10F; write only when idle.
// Timing:
//   Two register stages: lane stage (clamp, rebias, small-float rounding,
//   shared maximum) and merge stage (align, round, pack). One item is taken
//   every cycle while the output is not stalled. The merge stage is the
//   output register.
// Stall:
//   When out_tready is low a full output register holds; in_tready drops
//   only when both stages hold an item and the output is stalled.
// Reset:
//   rst_n clears valids and the rounding register; no items are in flight.
// ----------------------------------------------------------------------------
module hdr_color_packer
  import hcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // red[31:0], green[63:32], blue[95:64]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // packed_res
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic        rhe_r;
  logic [31:0] f11_u  [NumLanes];
  logic [31:0] e5_x   [NumLanes];
  logic [31:0] f11_r  [NumLanes];
  logic [31:0] e5_r   [NumLanes];
  logic [31:0] mx;
  logic [7:0]  eb_nxt;
  logic [7:0]  eb_r;
  s1_ctl_t     s1_r;
  logic        s1_adv;
  logic        s2_load;
  logic [8:0]  mant [NumLanes];
  logic [31:0] pack_nxt;
  logic [31:0] out_r;
  logic        out_valid_r;
  logic [31:0] sum;
  logic [4:0]  ef;

  // Lanes
  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    hcp_lane #(.LSB(i == 2 ? 18 : 17)) u_lane (
      .x(in_tdata[32*i +: 32]), .rhe(rhe_r), .f11_u(f11_u[i]), .e5_x(e5_x[i])
    );
    hcp_mant u_mant (.x(e5_r[i]), .eb(eb_r), .mant(mant[i]));
  end

  // Shared maximum exponent
  always_comb begin
    mx = FloorE5;
    for (int i = 0; i < NumLanes; i++) if (e5_x[i] > mx) mx = e5_x[i];
    sum    = mx + BiasE5;
    eb_nxt = sum[30:23];
  end

  assign s2_load   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_r.valid || s2_load;
  assign in_tready = s1_adv;

  // Hold the rounding register
  always_ff @(posedge clk) begin
    if (!rst_n) rhe_r <= 1'b0;
    else if (cfg_we) rhe_r <= cfg_wdata;
  end

  // Lane stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '{valid: 1'b0, op: OP_F11};
    end else if (s1_adv) begin
      s1_r <= '{valid: in_tvalid, op: op_t'(in_tuser)};
    end
  end
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      f11_r <= f11_u;
      e5_r  <= e5_x;
      eb_r  <= eb_nxt;
    end
  end

  // Merge and pack
  always_comb begin
    ef = 5'(eb_r + 8'd2);
    if (s1_r.op == OP_E5)
      pack_nxt = {ef, mant[2], mant[1], mant[0]};
    else
      pack_nxt = {f11_r[2][27:18], f11_r[1][27:17], f11_r[0][27:17]};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (s2_load) out_valid_r <= s1_r.valid;
  end
  always_ff @(posedge clk) begin
    if (s2_load && s1_r.valid) out_r <= pack_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule

// ----- design/hcp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_checker: port-level checks of the HDR color packer
// Watches handshakes on both channels.
// ----------------------------------------------------------------------------
module hcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled item changed");

  // Empty output means input side is open
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // No result once an idle input with the output ready has drained both stages
  a_nogen: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready) && out_tready ##1 !(in_tvalid && in_tready) && out_tready
    |=> !out_tvalid)
    else $error("item appeared without input");

endmodule

bind hdr_color_packer hcp_checker u_hcp_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the HDR color packer
// Drives float RGB items in both formats through the stream input, predicts
// each packed word and compares it with the stream output, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import hcp_pkg::*;

  typedef struct {
    op_t         op;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic        cfg_wdata;

  pixel_t      pending_px[$];
  logic [31:0] expected_words[$];
  logic        rhe_mode;
  int          n_fail;
  int          n_words;
  int          n_pixels;
  int          idle_cycles;
  bit          src_pause;
  bit          quiet_tail;
  bit          sink_hold;
  int          src_gap;
  int          sink_gap;

  hdr_color_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shift right keeping round-to-nearest-even on the dropped bits
  function automatic logic [31:0] shr_even(logic [31:0] m, logic [31:0] s);
    logic [31:0] q;
    logic [31:0] r;
    logic [31:0] half;
    if (s == 0) return m;
    if (s > 25) return 0;
    q = m >> s;
    r = m & ((32'd1 << s) - 1);
    half = 32'd1 << (s - 1);
    if (r > half || (r == half && q[0])) q = q + 1;
    return q;
  endfunction

  // One small-float channel, still in single-precision bit positions
  function automatic logic [31:0] small_chan(logic [31:0] x, int lsb, logic [31:0] mask,
                                             logic rhe);
    logic [31:0] e;
    logic [31:0] u;
    if (x[31]) x = 0;
    else if (x > ClampF11) x = ClampF11;
    e = x >> 23;
    if (e > 112) u = x - Rebias112;
    else if (e == 0) u = 0;
    else u = shr_even(32'h0080_0000 | (x & F32Frac), 113 - e);
    if (rhe) u = u + ((32'd1 << (lsb - 1)) - 1) + ((u >> lsb) & 1);
    else u = u + (32'd1 << (lsb - 1));
    return u & mask;
  endfunction

  function automatic logic [31:0] clamp_shared(logic [31:0] x);
    if (x[31]) return 0;
    if ((x & F32ExpMask) == F32ExpMask && (x & F32Frac) != 0) return 0;
    if (x > ClampE5) return ClampE5;
    return x;
  endfunction

  function automatic logic [31:0] shared_mant(logic [31:0] x, logic [31:0] eb);
    logic [31:0] ex;
    logic [31:0] m;
    ex = x >> 23;
    m = x & F32Frac;
    if (ex == 0) ex = 1;
    else m = m | 32'h0080_0000;
    return shr_even(m, eb + 15 - ex) & 32'd511;
  endfunction

  // Packed word for one pixel under the given rounding mode
  function automatic logic [31:0] pack_pixel(pixel_t p, logic rhe);
    logic [31:0] r, g, b, mx, eb, ef;
    if (p.op == OP_F11) begin
      r = small_chan(p.red, 17, 32'h0FFE_0000, rhe);
      g = small_chan(p.green, 17, 32'h0FFE_0000, rhe);
      b = small_chan(p.blue, 18, 32'h0FFC_0000, rhe);
      return (r >> 17) | (g >> 6) | (b << 4);
    end
    r = clamp_shared(p.red);
    g = clamp_shared(p.green);
    b = clamp_shared(p.blue);
    mx = FloorE5;
    if (r > mx) mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    eb = ((mx + BiasE5) & F32ExpMask) >> 23;
    ef = (eb + 2) & 31;
    return (ef << 27) | (shared_mant(b, eb - 15) << 18)
         | (shared_mant(g, eb - 15) << 9) | shared_mant(r, eb - 15);
  endfunction

  // Channel value biased toward interesting float classes
  function automatic logic [31:0] rand_chan();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hFF;
      1: v[30:23] = 8'h00;
      2: v = {1'b0, 8'(($urandom_range(100, 115))), v[22:0]};
      3: v = {1'b0, 8'(($urandom_range(140, 143))), v[22:0]};
      4: v = {1'b0, 8'(($urandom_range(100, 150))), v[22:17], 17'h10000};
      5: v = {1'b0, 8'(($urandom_range(100, 150))), v[22:18], 18'h20000};
      6: v = {1'b0, 8'(($urandom_range(100, 143))), v[22:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_pixel(op_t op, logic [31:0] r, logic [31:0] g, logic [31:0] b);
    pixel_t p;
    p.op = op;
    p.red = r;
    p.green = g;
    p.blue = b;
    pending_px.push_back(p);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      add_pixel(op_t'($urandom_range(0, 1)), rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  // Wait until the pipe has drained, then write the rounding register
  task automatic set_rounding(logic v);
    while (pending_px.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rhe_mode = v;
  endtask

  // Driver: present the head item, predict at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_words.push_back(pack_pixel(pending_px.pop_front(), rhe_mode));
        n_pixels++;
      end
      if (src_gap > 0) src_gap--;
      else if (!quiet_tail && $urandom_range(0, 19) == 0) src_gap = $urandom_range(1, 10);
      if (in_tvalid && !in_tready) begin
        // Hold the waiting item until it is taken
        in_tvalid <= 1'b1;
      end else if (pending_px.size() != 0 && !src_pause && src_gap == 0) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending_px[0].op;
        in_tdata <= {pending_px[0].blue, pending_px[0].green, pending_px[0].red};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_words++;
        if (expected_words.size() == 0) begin
          $error("packed_res: no word expected, got %h", out_tdata);
          n_fail++;
        end else begin
          if (out_tdata !== expected_words[0]) begin
            $error("packed_res: expected %h, actual %h", expected_words[0], out_tdata);
            n_fail++;
          end
          void'(expected_words.pop_front());
        end
      end
      if (sink_gap > 0) sink_gap--;
      else if (!quiet_tail && $urandom_range(0, 19) == 0) sink_gap = $urandom_range(1, 10);
      out_tready <= !sink_hold && sink_gap == 0;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    n_fail = 0;
    n_words = 0;
    n_pixels = 0;
    idle_cycles = 0;
    src_pause = 1'b0;
    quiet_tail = 1'b0;
    sink_hold = 1'b0;
    src_gap = 0;
    sink_gap = 0;
    rhe_mode = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zeros, negatives, NaNs, infinities, clamps, denormals, ties
    for (int m = 0; m < 2; m++) begin
      add_pixel(op_t'(m), 32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
      add_pixel(op_t'(m), 32'h7FC0_0000, 32'h7F80_0000, 32'h7F7F_FFFF);
      add_pixel(op_t'(m), 32'h477F_FFFF, 32'h4780_0000, 32'h477F_8000);
      add_pixel(op_t'(m), 32'h0000_0001, 32'h007F_FFFF, 32'h3880_0000);
      add_pixel(op_t'(m), 32'h3F81_0000, 32'h3F83_0000, 32'h3F82_0000);
      add_pixel(op_t'(m), 32'h3800_0000, 32'h3780_0000, 32'h3800_1000);
      add_pixel(op_t'(m), 32'h3F80_0000, 32'h3710_0000, 32'h4000_0000);
      add_pixel(op_t'(m), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    end
    add_random(200);

    // Long output stall with the input still offered
    while (pending_px.size() > 150) @(posedge clk);
    sink_hold = 1'b1;
    repeat (60) @(posedge clk);
    sink_hold = 1'b0;

    // Sender pauses until the pipe has drained
    while (pending_px.size() != 0) @(posedge clk);
    src_pause = 1'b1;
    add_random(50);
    while (expected_words.size() != 0) @(posedge clk);
    src_pause = 1'b0;

    set_rounding(1'b1);
    for (int m = 0; m < 2; m++) begin
      add_pixel(op_t'(m), 32'h3F81_0000, 32'h3F83_0000, 32'h3F82_0000);
      add_pixel(op_t'(m), 32'h3F86_0000, 32'h477F_FFFF, 32'h3F86_0000);
    end
    add_random(600);
    set_rounding(1'b0);
    add_random(400);
    set_rounding(1'b1);
    add_random(300);
    while (pending_px.size() > 100) @(posedge clk);
    quiet_tail = 1'b1;

    while (pending_px.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d pixels in both packed formats, both rounding modes,", n_pixels);
    $display("%0d words checked, with stalls and pauses on both sides", n_words);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- hdr_color_packer.f -----
design/hcp_pkg.sv
design/hcp_lane.sv
design/hcp_mant.sv
design/hdr_color_packer.sv
design/hcp_checker.sv
test/tb_top.sv
